// ===== hdl/rgb_to_gray_with_histogram_macros.svh =====
// ---------------------------------------------------------------------------
// RGB to gray assertion macros
// Shared concurrent assertion forms for the gray converter checkers.
// ---------------------------------------------------------------------------
`ifndef RGB_TO_GRAY_WITH_HISTOGRAM_MACROS_SVH
`define RGB_TO_GRAY_WITH_HISTOGRAM_MACROS_SVH

// same-cycle implication, off during reset
`define RTGH_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rtgh assertion failed");

// next-cycle implication, off during reset
`define RTGH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rtgh assertion failed");

// next-cycle implication, active in reset too
`define RTGH_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("rtgh assertion failed");

`endif

// ===== hdl/rtgh_pkg.sv =====
// ---------------------------------------------------------------------------
// rtgh_pkg
// Types, constants and helpers shared by the RGB to gray histogram block.
// ---------------------------------------------------------------------------
package rtgh_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int WEIGHT_W    = 15;
    localparam int PIX_W       = 8;
    localparam int GRAY_W      = 8;
    localparam int PAIR_W      = 7;
    localparam int HALF_W      = 16;
    localparam int HIST_OUT_W  = 2 * HALF_W;
    localparam int FRAC_W      = 15;
    localparam int PROD_W      = PIX_W + WEIGHT_W;
    localparam int SUM_W       = PROD_W + 2;
    localparam int LEVEL_W     = SUM_W - FRAC_W;
    localparam int ROWS        = 1 << PAIR_W;
    localparam int ROW_W       = 2 * COUNT_WIDTH;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int S_DATA_W    = 32;
    localparam int S_USER_W    = 2;
    localparam int M_DATA_W    = GRAY_W + HIST_OUT_W;
    localparam int APB_AW      = 4;
    localparam int APB_DW      = 32;

    localparam logic [SUM_W-1:0]   HALF_Q15 = SUM_W'(1) << (FRAC_W - 1);
    localparam logic [LEVEL_W-1:0] GRAY_MAX = LEVEL_W'(255);

    typedef logic [1:0] t_req;
    localparam t_req REQ_CONVERT = 2'd0;
    localparam t_req REQ_READ    = 2'd1;
    localparam t_req REQ_CLEAR   = 2'd2;

    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_WEIGHT_RED   = 2'd0;
    localparam t_reg_idx REG_WEIGHT_GREEN = 2'd1;
    localparam t_reg_idx REG_WEIGHT_BLUE  = 2'd2;

    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_RED   = 15'd9794;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_GREEN = 15'd19235;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_BLUE  = 15'd3736;

    typedef struct packed {
        logic [WEIGHT_W-1:0] red;
        logic [WEIGHT_W-1:0] green;
        logic [WEIGHT_W-1:0] blue;
    } t_weights;

    typedef struct packed {
        t_req              req;
        logic [GRAY_W-1:0] gray;
        logic [PAIR_W-1:0] pair;
    } t_item;

    function automatic logic [HALF_W-1:0] low_half(input logic [COUNT_WIDTH-1:0] cnt);
        logic [COUNT_WIDTH+HALF_W-1:0] ext;
        ext = {{HALF_W{1'b0}}, cnt};
        return ext[HALF_W-1:0];
    endfunction

endpackage

// ===== hdl/rgb_to_gray_with_histogram.sv =====
// ---------------------------------------------------------------------------
// rgb_to_gray_with_histogram
// RGB to gray conversion with weighted Q0.15 sum and a 256-bin histogram.
//
//   Channel   Direction  Beat contents
//   s_axis    in         tuser: req_type; tdata: red, green, blue, pair_index
//   m_axis    out        tdata: gray, hist_pair
//   apb       in/out     weight_red @0x0, weight_green @0x4, weight_blue @0x8
//
// One request per clock in and one result per clock out, when not stalled.
// Between input transfer and result transfer lie the product register, the
// queue slot, the histogram row read and the result register.
// A clear request drops all per-row valid bits at once.
// There is no clearing pass over the memory at reset.
// Front and back stall independently through a four-entry queue.
// ---------------------------------------------------------------------------
module rgb_to_gray_with_histogram import rtgh_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,  // red, green, blue, pair_index, pad
    input  logic [S_USER_W-1:0] s_axis_tuser,  // req_type
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata,  // gray, hist_pair
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    t_weights w_weights;
    t_item    w_push_item;
    t_item    w_head_item;
    logic     w_push;
    logic     w_full;
    logic     w_pop;
    logic     w_empty;

    rtgh_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_weights (w_weights)
    );

    rtgh_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_weights (w_weights),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_data    (s_axis_tdata),
        .i_user    (s_axis_tuser),
        .o_push    (w_push),
        .o_item    (w_push_item),
        .i_full    (w_full)
    );

    rtgh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_item  (w_head_item),
        .o_empty (w_empty)
    );

    rtgh_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (w_head_item),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

endmodule

// ===== hdl/rtgh_cfg.sv =====
// ---------------------------------------------------------------------------
// rtgh_cfg
// APB register file holding the three Q0.15 color weights.
// ---------------------------------------------------------------------------
module rtgh_cfg import rtgh_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_weights          o_weights
);

    t_weights r_weights;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready    = 1'b1;
    assign w_idx     = paddr[3:2];
    assign w_wr      = psel && penable && pwrite && pready;
    assign o_weights = r_weights;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weights.red   <= RST_WEIGHT_RED;
            r_weights.green <= RST_WEIGHT_GREEN;
            r_weights.blue  <= RST_WEIGHT_BLUE;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_WEIGHT_RED:   r_weights.red   <= pwdata[WEIGHT_W-1:0];
                REG_WEIGHT_GREEN: r_weights.green <= pwdata[WEIGHT_W-1:0];
                REG_WEIGHT_BLUE:  r_weights.blue  <= pwdata[WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_WEIGHT_RED:   prdata = APB_DW'(r_weights.red);
            REG_WEIGHT_GREEN: prdata = APB_DW'(r_weights.green);
            REG_WEIGHT_BLUE:  prdata = APB_DW'(r_weights.blue);
            default:          prdata = '0;
        endcase
    end

endmodule

// ===== hdl/rtgh_front.sv =====
// ---------------------------------------------------------------------------
// rtgh_front
// Accepts requests, forms the weighted products and the rounded gray level.
// ---------------------------------------------------------------------------
module rtgh_front import rtgh_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_weights            i_weights,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [S_DATA_W-1:0] i_data,   // red, green, blue, pair_index
    input  logic [S_USER_W-1:0] i_user,   // req_type
    output logic                o_push,
    output t_item               o_item,
    input  logic                i_full
);

    logic              r_p_valid;
    t_req              r_p_req;
    logic [PAIR_W-1:0] r_p_pair;
    logic [PROD_W-1:0] r_prod_r;
    logic [PROD_W-1:0] r_prod_g;
    logic [PROD_W-1:0] r_prod_b;

    logic               w_take;
    logic [SUM_W-1:0]   w_sum;
    logic [LEVEL_W-1:0] w_level;
    logic [GRAY_W-1:0]  w_gray;

    assign o_ready = !r_p_valid || !i_full;
    assign w_take  = i_valid && o_ready;
    assign o_push  = r_p_valid && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (w_take) begin
            r_p_valid <= 1'b1;
        end else if (o_push) begin
            r_p_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_p_req  <= i_user;
            r_p_pair <= i_data[3*PIX_W +: PAIR_W];
            r_prod_r <= PROD_W'(i_data[0 +: PIX_W]) * PROD_W'(i_weights.red);
            r_prod_g <= PROD_W'(i_data[PIX_W +: PIX_W]) * PROD_W'(i_weights.green);
            r_prod_b <= PROD_W'(i_data[2*PIX_W +: PIX_W]) * PROD_W'(i_weights.blue);
        end
    end

    assign w_sum   = SUM_W'(r_prod_r) + SUM_W'(r_prod_g) + SUM_W'(r_prod_b) + HALF_Q15;
    assign w_level = w_sum[SUM_W-1:FRAC_W];
    assign w_gray  = (w_level > GRAY_MAX) ? GRAY_MAX[GRAY_W-1:0] : w_level[GRAY_W-1:0];

    always_comb begin
        o_item.req  = r_p_req;
        o_item.pair = r_p_pair;
        o_item.gray = (r_p_req == REQ_CONVERT) ? w_gray : '0;
    end

endmodule

// ===== hdl/rtgh_queue.sv =====
// ---------------------------------------------------------------------------
// rtgh_queue
// Short request queue between the front and the histogram back end.
// ---------------------------------------------------------------------------
module rtgh_queue import rtgh_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_empty
);

    t_item               r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW:0]   r_wptr;
    logic [QUEUE_AW:0]   r_rptr;

    assign o_empty = (r_wptr == r_rptr);
    assign o_full  = (r_wptr[QUEUE_AW] != r_rptr[QUEUE_AW])
                  && (r_wptr[QUEUE_AW-1:0] == r_rptr[QUEUE_AW-1:0]);
    assign o_item  = r_slot[r_rptr[QUEUE_AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_slot[r_wptr[QUEUE_AW-1:0]] <= i_item;
        end
    end

endmodule

// ===== hdl/rtgh_back.sv =====
// ---------------------------------------------------------------------------
// rtgh_back
// Histogram memory with read-modify-write, bin pair reads, clear, and the
// result output register.
// ---------------------------------------------------------------------------
module rtgh_back import rtgh_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_item               i_item,
    input  logic                i_empty,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [M_DATA_W-1:0] o_data    // gray, hist_pair
);

    logic [ROW_W-1:0]      r_mem [ROWS];
    logic [ROW_W-1:0]      r_rdata;
    logic [ROWS-1:0]       r_hvalid;
    logic                  r_b_valid;
    t_item                 r_b_item;
    logic [PAIR_W-1:0]     r_b_row;
    logic                  r_fwd_valid;
    logic [PAIR_W-1:0]     r_fwd_row;
    logic [ROW_W-1:0]      r_fwd_data;
    logic                  r_m_valid;
    logic [GRAY_W-1:0]     r_m_gray;
    logic [HIST_OUT_W-1:0] r_m_pair;

    logic                   w_adv;
    logic                   w_wr;
    logic                   w_clr;
    logic [PAIR_W-1:0]      w_head_row;
    logic [ROW_W-1:0]       w_row;
    logic [COUNT_WIDTH-1:0] w_lo;
    logic [COUNT_WIDTH-1:0] w_hi;
    logic [ROW_W-1:0]       w_wdata;

    assign w_adv = r_b_valid && (!r_m_valid || i_ready);
    assign o_pop = !i_empty && (!r_b_valid || w_adv);
    assign w_wr  = w_adv && (r_b_item.req == REQ_CONVERT);
    assign w_clr = w_adv && (r_b_item.req == REQ_CLEAR);

    assign w_head_row = (i_item.req == REQ_CONVERT) ? i_item.gray[GRAY_W-1:1] : i_item.pair;

    always_comb begin
        if (r_fwd_valid && (r_fwd_row == r_b_row)) begin
            w_row = r_fwd_data;
        end else if (r_hvalid[r_b_row]) begin
            w_row = r_rdata;
        end else begin
            w_row = '0;
        end
        w_lo = w_row[COUNT_WIDTH-1:0];
        w_hi = w_row[ROW_W-1:COUNT_WIDTH];
        if (r_b_item.gray[0]) begin
            w_wdata = {w_hi + COUNT_WIDTH'(1), w_lo};
        end else begin
            w_wdata = {w_hi, w_lo + COUNT_WIDTH'(1)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_b_row] <= w_wdata;
        end
        if (o_pop) begin
            r_rdata <= r_mem[w_head_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_hvalid    <= '0;
            r_fwd_valid <= 1'b0;
            r_m_valid   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_b_valid <= 1'b1;
            end else if (w_adv) begin
                r_b_valid <= 1'b0;
            end
            if (w_clr) begin
                r_hvalid    <= '0;
                r_fwd_valid <= 1'b0;
            end else if (w_wr) begin
                r_hvalid[r_b_row] <= 1'b1;
                r_fwd_valid       <= 1'b1;
            end
            if (w_adv) begin
                r_m_valid <= 1'b1;
            end else if (i_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b_item <= i_item;
            r_b_row  <= w_head_row;
        end
        if (w_wr) begin
            r_fwd_row  <= r_b_row;
            r_fwd_data <= w_wdata;
        end
        if (w_adv) begin
            r_m_gray <= r_b_item.gray;
            if (r_b_item.req == REQ_READ) begin
                r_m_pair <= {low_half(w_hi), low_half(w_lo)};
            end else begin
                r_m_pair <= '0;
            end
        end
    end

    assign o_valid = r_m_valid;
    assign o_data  = {r_m_pair, r_m_gray};

endmodule

// ===== hdl/rtgh_checker.sv =====
// ---------------------------------------------------------------------------
// rtgh_checker
// Port-level checks for the RGB to gray histogram block.
// ---------------------------------------------------------------------------
`include "rgb_to_gray_with_histogram_macros.svh"

module rtgh_checker import rtgh_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_m_tvalid,
    input logic                i_m_tready,
    input logic [M_DATA_W-1:0] i_m_tdata,
    input logic [APB_DW-1:0]   i_prdata
);

    `RTGH_ASSERT_ALWAYS_NEXT(a_rst_clears_out, i_clk, !i_rst_n, !i_m_tvalid)
    `RTGH_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata))
    `RTGH_ASSERT_IMPL(a_gray_or_pair, i_clk, i_rst_n, i_m_tvalid && (i_m_tdata[GRAY_W-1:0] != '0), i_m_tdata[M_DATA_W-1:GRAY_W] == '0)
    `RTGH_ASSERT_IMPL(a_weight_width, i_clk, i_rst_n, 1'b1, i_prdata[APB_DW-1:WEIGHT_W] == '0)

endmodule

bind rgb_to_gray_with_histogram rtgh_checker u_rtgh_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_prdata   (prdata)
);
